// ===== src/psac_pkg.sv =====
// Shared types and constants for the polygon scaling block.
package psac_pkg;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // Result coordinate width (signed, 8 fraction bits) and vertex number width.
    localparam int OUT_W  = 30;
    localparam int VNUM_W = 4;

    // Scale factors are signed Q8.8; 1.0 is 256.
    localparam int SCALE_W = 16;
    localparam int Q88_ONE = 256;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // Configuration port: register select is address bit 2.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_SCALE_X = 1'b0;
    localparam logic REG_SCALE_Y = 1'b1;

endpackage

// ===== src/polygon_scale_about_centroid.sv =====
// Polygon scaling about the integer centroid, built around a vertex store memory.
//
//  Channel | Ports            | tdata / tuser / tlast
//  --------+------------------+--------------------------------------------------
//  input   | s_tvalid/tready  | tdata: vertex_x, vertex_y; tlast: final_vertex
//  result  | m_tvalid/tready  | tdata: scaled_x, scaled_y, vertex_number;
//          |                  | tlast: end_of_polygon; tuser: dropped_vertices
//  config  | APB psel/penable | 0x0 scale_x, 0x4 scale_y (signed Q8.8)
//
// Vertices load at one per cycle; each up to MAX_VERTICES goes to the store and is added
// to the sums, later ones are dropped and flagged. After the last vertex come a setup
// state, the bit-serial centroid divider and the centroid term, then a three-stage read
// and multiply pipeline delivers one result per cycle while the result side takes them.
// Input is not taken from the last vertex until the last result has been taken.
// Reset is synchronous and spares the store; count, sums, flags, counters, scales reset.
// A stall on the result side freezes the whole emission pipeline including the read.
module polygon_scale_about_centroid #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 12
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    // Input request.
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // vertex_x [COORD_BITS-1:0], vertex_y [2*COORD_BITS-1:COORD_BITS], zero pad above
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]             s_tdata,
    input  logic                                          s_tlast,
    // Result request.
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // scaled_x [29:0], scaled_y [59:30], vertex_number [63:60]
    output logic [2*psac_pkg::OUT_W+psac_pkg::VNUM_W-1:0] m_tdata,
    output logic                                          m_tlast,
    // dropped_vertices [0]
    output logic                                          m_tuser,
    // Configuration port.
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [psac_pkg::CFG_AW-1:0]                   paddr,
    input  logic [psac_pkg::CFG_DW-1:0]                   pwdata,
    output logic [psac_pkg::CFG_DW-1:0]                   prdata,
    output logic                                          pready
);
    import psac_pkg::*;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W  = COORD_BITS + $clog2(MAX_VERTICES);
    localparam int DC_W   = $clog2(SUM_W + 1);
    localparam int PR_W   = (COORD_BITS + SCALE_W > OUT_W) ? COORD_BITS + SCALE_W : OUT_W;
    localparam int CT_W   = (COORD_BITS + SCALE_W + 1 > OUT_W) ?
                            COORD_BITS + SCALE_W + 1 : OUT_W;
    localparam int ENTRY_W = 2 * COORD_BITS;

    // Vertex store and its registered read port.
    logic [ENTRY_W-1:0] vstore [MAX_VERTICES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    // Control state.
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic                      ovf_reg, ovf_next;
    logic [DC_W-1:0]           div_cnt_reg, div_cnt_next;
    logic [SCALE_W-1:0]        scale_x_reg, scale_x_next;
    logic [SCALE_W-1:0]        scale_y_reg, scale_y_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic                      v1_reg, v1_next;
    logic                      v2_reg, v2_next;
    logic                      m_tvalid_reg, m_tvalid_next;

    // Datapath registers.
    logic [SUM_W-1:0]          num_x_reg, num_x_next;
    logic [SUM_W-1:0]          num_y_reg, num_y_next;
    logic [CNT_W-1:0]          rem_x_reg, rem_x_next;
    logic [CNT_W-1:0]          rem_y_reg, rem_y_next;
    logic [OUT_W-1:0]          ctx_reg, ctx_next;
    logic [OUT_W-1:0]          cty_reg, cty_next;
    logic [IDX_W-1:0]          idx1_reg, idx1_next;
    logic                      last1_reg, last1_next;
    logic [IDX_W-1:0]          idx2_reg, idx2_next;
    logic                      last2_reg, last2_next;
    logic [OUT_W-1:0]          px_reg, px_next;
    logic [OUT_W-1:0]          py_reg, py_next;
    logic [OUT_W-1:0]          ox_reg, ox_next;
    logic [OUT_W-1:0]          oy_reg, oy_next;
    logic [VNUM_W-1:0]         onum_reg, onum_next;
    logic                      olast_reg, olast_next;
    logic                      odrop_reg, odrop_next;

    // Combinational helpers.
    logic signed [COORD_BITS-1:0] vin_x, vin_y;
    logic signed [COORD_BITS-1:0] mem_x, mem_y;
    logic [CNT_W:0]               rsh_x, rsh_y;
    logic                         qb_x, qb_y;
    logic signed [SUM_W-1:0]      q_sx, q_sy;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic signed [SCALE_W:0]      dif_x, dif_y;
    logic signed [CT_W-1:0]       cprod_x, cprod_y;
    logic signed [PR_W-1:0]       prod_x, prod_y;
    logic                         adv;
    logic                         cfg_we;

    assign vin_x = $signed(s_tdata[COORD_BITS-1:0]);
    assign vin_y = $signed(s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign mem_x = $signed(rd_data_reg[COORD_BITS-1:0]);
    assign mem_y = $signed(rd_data_reg[2*COORD_BITS-1:COORD_BITS]);

    // One restoring divide step per cycle for each axis; quotient bits shift into num.
    assign rsh_x = {rem_x_reg, num_x_reg[SUM_W-1]};
    assign rsh_y = {rem_y_reg, num_y_reg[SUM_W-1]};
    assign qb_x  = (rsh_x >= {1'b0, count_reg});
    assign qb_y  = (rsh_y >= {1'b0, count_reg});

    // Signed centroid: quotient magnitude with the sign of the sum.
    assign q_sx = sum_x_reg[SUM_W-1] ? -$signed(num_x_reg) : $signed(num_x_reg);
    assign q_sy = sum_y_reg[SUM_W-1] ? -$signed(num_y_reg) : $signed(num_y_reg);
    assign cx   = COORD_BITS'(q_sx);
    assign cy   = COORD_BITS'(q_sy);

    // Centroid term c*(1.0 - s), kept modulo the result width.
    assign dif_x   = (SCALE_W+1)'(Q88_ONE) - (SCALE_W+1)'($signed(scale_x_reg));
    assign dif_y   = (SCALE_W+1)'(Q88_ONE) - (SCALE_W+1)'($signed(scale_y_reg));
    assign cprod_x = CT_W'(cx) * CT_W'(dif_x);
    assign cprod_y = CT_W'(cy) * CT_W'(dif_y);

    // Vertex term p*s on the word read from the store.
    assign prod_x = PR_W'(mem_x) * PR_W'($signed(scale_x_reg));
    assign prod_y = PR_W'(mem_y) * PR_W'($signed(scale_y_reg));

    // The emission pipeline moves as one whenever the output register can take a result.
    assign adv     = !m_tvalid_reg || m_tready;
    assign rd_en   = (state_reg == ST_EMIT) && adv && (issue_reg < count_reg);
    assign rd_addr = issue_reg[IDX_W-1:0];

    assign s_tready = (state_reg == ST_LOAD);
    assign mem_we   = s_tvalid && s_tready && (count_reg < CNT_W'(MAX_VERTICES));
    assign cfg_we   = psel && penable && pwrite;

    // Next state, load, divide, and emission control.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        ovf_next      = ovf_reg;
        div_cnt_next  = div_cnt_reg;
        issue_next    = issue_reg;
        num_x_next    = num_x_reg;
        num_y_next    = num_y_reg;
        rem_x_next    = rem_x_reg;
        rem_y_next    = rem_y_reg;
        ctx_next      = ctx_reg;
        cty_next      = cty_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    if (mem_we) begin
                        sum_x_next = sum_x_reg + SUM_W'(vin_x);
                        sum_y_next = sum_y_reg + SUM_W'(vin_y);
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                num_x_next   = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
                num_y_next   = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
                rem_x_next   = '0;
                rem_y_next   = '0;
                div_cnt_next = DC_W'(SUM_W);
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                num_x_next   = {num_x_reg[SUM_W-2:0], qb_x};
                num_y_next   = {num_y_reg[SUM_W-2:0], qb_y};
                rem_x_next   = qb_x ? CNT_W'(rsh_x - {1'b0, count_reg}) : CNT_W'(rsh_x);
                rem_y_next   = qb_y ? CNT_W'(rsh_y - {1'b0, count_reg}) : CNT_W'(rsh_y);
                div_cnt_next = div_cnt_reg - DC_W'(1);
                if (div_cnt_reg == DC_W'(1)) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                ctx_next   = cprod_x[OUT_W-1:0];
                cty_next   = cprod_y[OUT_W-1:0];
                issue_next = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                // The polygon is done once its last result is taken.
                if (m_tvalid_reg && m_tready && olast_reg) begin
                    count_next = '0;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Emission pipeline: store read, products, output register.
    always_comb begin
        v1_next       = v1_reg;
        idx1_next     = idx1_reg;
        last1_next    = last1_reg;
        v2_next       = v2_reg;
        idx2_next     = idx2_reg;
        last2_next    = last2_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        m_tvalid_next = m_tvalid_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        onum_next     = onum_reg;
        olast_next    = olast_reg;
        odrop_next    = odrop_reg;
        if (adv) begin
            v1_next       = rd_en;
            idx1_next     = rd_addr;
            last1_next    = (issue_reg == count_reg - CNT_W'(1));
            v2_next       = v1_reg;
            idx2_next     = idx1_reg;
            last2_next    = last1_reg;
            px_next       = prod_x[OUT_W-1:0];
            py_next       = prod_y[OUT_W-1:0];
            m_tvalid_next = v2_reg;
            ox_next       = px_reg + ctx_reg;
            oy_next       = py_reg + cty_reg;
            onum_next     = VNUM_W'(idx2_reg);
            olast_next    = last2_reg;
            odrop_next    = ovf_reg;
        end
    end

    // Configuration register writes and reads.
    always_comb begin
        scale_x_next = scale_x_reg;
        scale_y_next = scale_y_reg;
        if (cfg_we) begin
            unique case (paddr[2])
                REG_SCALE_X: scale_x_next = pwdata[SCALE_W-1:0];
                REG_SCALE_Y: scale_y_next = pwdata[SCALE_W-1:0];
                default:     scale_x_next = scale_x_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCALE_X: prdata = CFG_DW'(scale_x_reg);
            REG_SCALE_Y: prdata = CFG_DW'(scale_y_reg);
            default:     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            ovf_reg      <= 1'b0;
            div_cnt_reg  <= '0;
            issue_reg    <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            scale_x_reg  <= SCALE_RESET;
            scale_y_reg  <= SCALE_RESET;
        end else begin
            count_reg    <= count_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            ovf_reg      <= ovf_next;
            div_cnt_reg  <= div_cnt_next;
            issue_reg    <= issue_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            m_tvalid_reg <= m_tvalid_next;
            scale_x_reg  <= scale_x_next;
            scale_y_reg  <= scale_y_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        num_x_reg <= num_x_next;
        num_y_reg <= num_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        ctx_reg   <= ctx_next;
        cty_reg   <= cty_next;
        idx1_reg  <= idx1_next;
        last1_reg <= last1_next;
        idx2_reg  <= idx2_next;
        last2_reg <= last2_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        onum_reg  <= onum_next;
        olast_reg <= olast_next;
        odrop_reg <= odrop_next;
    end

    // Vertex store. Writes happen only while loading and reads only while emitting,
    // so the two never touch the same entry in overlapping cycles.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vstore[count_reg[IDX_W-1:0]] <= {vin_y, vin_x};
        end
        if (rd_en) begin
            rd_data_reg <= vstore[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {onum_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
    assign m_tuser  = odrop_reg;

    // Results appear only while emitting.
    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> state_reg == ST_EMIT)
        else $error("result valid outside emission");

    // The vertex count never exceeds the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    // The divider never runs with an exhausted step counter.
    a_div_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> div_cnt_reg != '0)
        else $error("divider step counter underflow");

    // Taking the last result clears the polygon state and reopens the input.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=>
            state_reg == ST_LOAD && count_reg == '0 && !ovf_reg && !m_tvalid_reg)
        else $error("polygon state not cleared after last result");

    // The store is read only while emitting and with vertices held for this polygon.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> count_reg != '0 && state_reg == ST_EMIT)
        else $error("store read with no vertices held");

endmodule
